/* hw/rtl/ultrasonic_ranger_trimmed_mean_defines.svh */
// assertion macros used by the ranger top module
`ifndef ULTRASONIC_RANGER_TRIMMED_MEAN_DEFINES_SVH
`define ULTRASONIC_RANGER_TRIMMED_MEAN_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define URTM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("urtm check failed");

// next-cycle implication, clocked on clk_i, off during reset
`define URTM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("urtm check failed");

`endif

/* hw/rtl/urtm_pkg.sv */
package urtm_pkg;

  // sample count default
  localparam int SAMPLES_DEF = 5;

  // register field widths
  localparam int TRIG_W     = 8;
  localparam int TIMEOUT_W  = 16;
  localparam int PRESCALE_W = 4;
  localparam int MAXCNT_W   = 13;
  localparam int GAP_W      = 16;

  // datapath widths
  localparam int TICK_W   = 16;
  localparam int TICK1_W  = TICK_W + 1;
  localparam int SAMPLE_W = 14;
  localparam int TRIM_W   = 15;
  localparam int SCALED_W = 19;
  localparam int DIST_W   = 18;
  localparam int USED_W   = 2;

  // config port widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // reciprocal of three, exact for values below 2**21
  localparam int                RECIP_W     = 20;
  localparam int                RECIP_SHIFT = 21;
  localparam logic [RECIP_W-1:0] RECIP3     = 20'd699051;

  // register reset values
  localparam logic [TRIG_W-1:0]     TRIG_RST     = 8'd20;
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = 16'd20000;
  localparam logic [PRESCALE_W-1:0] PRESCALE_RST = 4'd10;
  localparam logic [MAXCNT_W-1:0]   MAXCNT_RST   = 13'd5000;
  localparam logic [GAP_W-1:0]      GAP_RST      = 16'd10000;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIGGER_TICKS  = 3'd0,
    REG_ECHO_TIMEOUT   = 3'd1,
    REG_COUNT_PRESCALE = 3'd2,
    REG_MAX_COUNT      = 3'd3,
    REG_GAP_TICKS      = 3'd4
  } cfg_reg_e;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic out_load_tick;
    logic out_load_done;
    logic out_trig;
    logic out_busy;
    logic tick_clr;
    logic tick_inc;
    logic idx_clr;
    logic cnt_step;
    logic cnt_restart;
    logic store_en;
    logic store_count;
    logic sweep_start;
    logic sweep_rd;
    logic scale_en;
    logic div_en;
  } urtm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic start;
    logic echo;
    logic trig_end;
    logic timeout;
    logic gap_end;
    logic last_sample;
    logic count_end;
    logic sweep_last;
  } urtm_status_t;

endpackage

/* hw/rtl/urtm_if.sv */
// tick input channel
interface urtm_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo;

  modport source (output valid, output start_req, output echo, input ready);
  modport sink   (input valid, input start_req, input echo, output ready);
endinterface

// per-tick result channel
interface urtm_out_if import urtm_pkg::*;;
  logic              valid;
  logic              ready;
  logic              trig;
  logic              busy_res;
  logic              done_res;
  logic [DIST_W-1:0] distance;
  logic [USED_W-1:0] used_samples;

  modport source (output valid, output trig, output busy_res, output done_res,
                  output distance, output used_samples, input ready);
  modport sink   (input valid, input trig, input busy_res, input done_res,
                  input distance, input used_samples, output ready);
endinterface

// register write channel
interface urtm_cfg_if import urtm_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/ultrasonic_ranger_trimmed_mean.sv */
// Ultrasonic ranger with a trimmed-mean filter over NumSamples readings.
// in_i carries one word per microsecond tick: start_req and the sampled echo
// level. res_o returns exactly one word per accepted tick: trig pin level,
// busy_res, done_res, distance (hundredths of a cm) and used_samples.
// cfg_i writes the five timing registers by index; it is always ready and a
// write takes effect on the next tick.
// An ordinary tick's word is registered and valid the cycle after the tick is
// accepted, so ticks flow at one per cycle while res_o keeps up.
// After the tick that closes the last gap, the sample store is read one entry
// per cycle, then the trimmed sum is scaled by 17 and divided by the used count
// through one multiplier stage. in_i stays not ready meanwhile.
// When res_o stalls, the pending word is held and in_i drops ready until it
// is taken; no tick is lost or repeated.
// Reset puts the registers at their defaults, the sequencer idle and the held
// distance at zero; there is no clearing pass.
`include "ultrasonic_ranger_trimmed_mean_defines.svh"

module ultrasonic_ranger_trimmed_mean import urtm_pkg::*; #(
  parameter int NumSamples = SAMPLES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  urtm_in_if.sink    in_i,
  urtm_out_if.source res_o,
  urtm_cfg_if.sink   cfg_i
);

  urtm_cmd_t    cmd;
  urtm_status_t status;

  // sequencer
  urtm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // counters, sample store, filter and output register
  urtm_datapath #(
    .NumSamples (NumSamples)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .res_o    (res_o),
    .cfg_i    (cfg_i),
    .cmd_i    (cmd),
    .status_o (status)
  );

  // a filtered word is never flagged idle or with trigger high
  `URTM_ASSERT_IMP(a_done_busy, res_o.valid && res_o.done_res, res_o.busy_res && !res_o.trig)
  // used count stays within the middle samples
  `URTM_ASSERT_IMP(a_used_range, res_o.valid && res_o.done_res,
                   res_o.used_samples <= USED_W'(NumSamples - 2))
  // ordinary ticks report no used samples
  `URTM_ASSERT_IMP(a_used_zero, res_o.valid && !res_o.done_res, res_o.used_samples == '0)
  // an accepted tick either has its word pending or starts the filter pass
  `URTM_ASSERT_NXT(a_tick_word, in_i.valid && in_i.ready, res_o.valid || !in_i.ready)

endmodule

/* hw/rtl/urtm_ctrl.sv */
module urtm_ctrl import urtm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  urtm_status_t status_i,
  output urtm_cmd_t    cmd_o
);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_TRIG  = 10'b0000000010,
    ST_WAIT  = 10'b0000000100,
    ST_COUNT = 10'b0000001000,
    ST_GAP   = 10'b0000010000,
    ST_SWEEP = 10'b0000100000,
    ST_DRAIN = 10'b0001000000,
    ST_SCALE = 10'b0010000000,
    ST_DIV   = 10'b0100000000,
    ST_EMIT  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   tick_state;
  logic   fire;

  // tick phases take one word per cycle while res_o has room, the filter states hold the input
  assign tick_state = (state_q == ST_IDLE) || (state_q == ST_TRIG) || (state_q == ST_WAIT) ||
                      (state_q == ST_COUNT) || (state_q == ST_GAP);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.in_ready    = tick_state && status_i.out_free;
    cmd_o.cnt_restart = (state_q == ST_WAIT);
    cmd_o.out_trig    = (state_q == ST_TRIG);
    cmd_o.out_busy    = (state_q != ST_IDLE);
    fire = cmd_o.in_ready && status_i.in_valid;
    unique case (state_q)
      ST_IDLE: begin
        if (fire) begin
          cmd_o.out_load_tick = 1'b1;
          if (status_i.start) begin
            cmd_o.tick_clr = 1'b1;
            cmd_o.idx_clr  = 1'b1;
            state_d        = ST_TRIG;
          end
        end
      end
      ST_TRIG: begin
        if (fire) begin
          cmd_o.out_load_tick = 1'b1;
          if (status_i.trig_end) begin
            cmd_o.tick_clr = 1'b1;
            state_d        = ST_WAIT;
          end else begin
            cmd_o.tick_inc = 1'b1;
          end
        end
      end
      ST_WAIT: begin
        if (fire) begin
          cmd_o.out_load_tick = 1'b1;
          if (status_i.echo) begin
            cmd_o.cnt_step = 1'b1;
            if (status_i.count_end) begin
              cmd_o.store_en    = 1'b1;
              cmd_o.store_count = 1'b1;
              cmd_o.tick_clr    = 1'b1;
              state_d           = ST_GAP;
            end else begin
              state_d = ST_COUNT;
            end
          end else if (status_i.timeout) begin
            cmd_o.store_en = 1'b1;
            cmd_o.tick_clr = 1'b1;
            state_d        = ST_GAP;
          end else begin
            cmd_o.tick_inc = 1'b1;
          end
        end
      end
      ST_COUNT: begin
        if (fire) begin
          cmd_o.out_load_tick = 1'b1;
          cmd_o.cnt_step      = 1'b1;
          if (status_i.count_end) begin
            cmd_o.store_en    = 1'b1;
            cmd_o.store_count = 1'b1;
            cmd_o.tick_clr    = 1'b1;
            state_d           = ST_GAP;
          end
        end
      end
      ST_GAP: begin
        if (fire) begin
          if (status_i.gap_end) begin
            cmd_o.tick_clr = 1'b1;
            if (status_i.last_sample) begin
              cmd_o.sweep_start = 1'b1;
              state_d           = ST_SWEEP;
            end else begin
              cmd_o.out_load_tick = 1'b1;
              state_d             = ST_TRIG;
            end
          end else begin
            cmd_o.out_load_tick = 1'b1;
            cmd_o.tick_inc      = 1'b1;
          end
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep_rd = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale_en = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_en = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_load_done = 1'b1;
          cmd_o.out_busy      = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/urtm_datapath.sv */
module urtm_datapath import urtm_pkg::*; #(
  parameter int NumSamples = SAMPLES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  urtm_in_if.sink       in_i,
  urtm_out_if.source    res_o,
  urtm_cfg_if.sink      cfg_i,
  input  urtm_cmd_t     cmd_i,
  output urtm_status_t  status_o
);

  localparam int AddrW = $clog2(NumSamples);
  localparam int IdxW  = $clog2(NumSamples + 1);
  localparam int TotW  = $clog2(NumSamples) + SAMPLE_W;
  localparam int ZW    = $clog2(NumSamples + 1);
  localparam int ProdW = SCALED_W + RECIP_W;

  // config registers
  logic [TRIG_W-1:0]     trig_ticks_q;
  logic [TIMEOUT_W-1:0]  timeout_q;
  logic [PRESCALE_W-1:0] prescale_q;
  logic [MAXCNT_W-1:0]   max_count_q;
  logic [GAP_W-1:0]      gap_q;

  // measurement state
  logic [TICK_W-1:0]     tick_q;
  logic [PRESCALE_W-1:0] pre_q;
  logic [SAMPLE_W-1:0]   ec_q;
  logic [IdxW-1:0]       idx_q;

  // sample store and sweep
  logic [SAMPLE_W-1:0]   mem_q [NumSamples];
  logic [SAMPLE_W-1:0]   rd_q;
  logic                  rd_vld_q;
  logic [AddrW-1:0]      sweep_idx_q;

  // accumulators and filter pipeline
  logic [TotW-1:0]       total_q;
  logic [SAMPLE_W-1:0]   min_q;
  logic [SAMPLE_W-1:0]   max_q;
  logic [ZW-1:0]         zcnt_q;
  logic [SCALED_W-1:0]   scaled_q, scaled_d;
  logic [USED_W-1:0]     n_q, n_d;
  logic [DIST_W-1:0]     dist_q, dist_d;

  // output register
  logic                  out_vld_q;
  logic                  out_trig_q;
  logic                  out_busy_q;
  logic                  out_done_q;
  logic [USED_W-1:0]     out_used_q;
  logic [DIST_W-1:0]     last_dist_q;

  // combinational helpers
  logic [TRIG_W-1:0]     tlen;
  logic [PRESCALE_W-1:0] per;
  logic [PRESCALE_W-1:0] pre_eff, pre_inc;
  logic [SAMPLE_W-1:0]   ec_eff, ec_inc;
  logic                  echo_eff;
  logic                  stop_low, wrap, over;
  logic [SAMPLE_W-1:0]   cnt_val, store_val;
  logic [TotW-1:0]       trimmed_full;
  logic [TRIM_W-1:0]     trimmed;
  logic [ProdW-1:0]      prod;
  logic                  out_load;

  // zero lengths count as one
  assign tlen = (trig_ticks_q == '0) ? TRIG_W'(1) : trig_ticks_q;
  assign per  = (prescale_q == '0) ? PRESCALE_W'(1) : prescale_q;

  // echo counting step, restart treats the rising tick as a fresh period
  assign pre_eff  = cmd_i.cnt_restart ? '0 : pre_q;
  assign ec_eff   = cmd_i.cnt_restart ? '0 : ec_q;
  assign echo_eff = cmd_i.cnt_restart | in_i.echo;
  assign stop_low = (pre_eff == '0) && !echo_eff;
  assign pre_inc  = pre_eff + PRESCALE_W'(1);
  assign wrap     = pre_inc >= per;
  assign ec_inc   = ec_eff + SAMPLE_W'(1);
  assign over     = wrap && (ec_inc > SAMPLE_W'(max_count_q));
  assign cnt_val  = stop_low ? ec_eff : ec_inc;
  assign store_val = cmd_i.store_count ? cnt_val : '0;

  // status to the controller
  assign status_o.in_valid    = in_i.valid;
  assign status_o.out_free    = !out_vld_q || res_o.ready;
  assign status_o.start       = in_i.start_req;
  assign status_o.echo        = in_i.echo;
  assign status_o.trig_end    = (TICK1_W'(tick_q) + TICK1_W'(1)) >= TICK1_W'(tlen);
  assign status_o.timeout     = tick_q >= timeout_q;
  assign status_o.gap_end     = tick_q >= gap_q;
  assign status_o.last_sample = idx_q >= IdxW'(NumSamples);
  assign status_o.count_end   = stop_low || over;
  assign status_o.sweep_last  = sweep_idx_q == AddrW'(NumSamples - 1);

  // channel outputs
  assign in_i.ready          = cmd_i.in_ready;
  assign cfg_i.ready         = 1'b1;
  assign res_o.valid         = out_vld_q;
  assign res_o.trig          = out_trig_q;
  assign res_o.busy_res      = out_busy_q;
  assign res_o.done_res      = out_done_q;
  assign res_o.distance      = last_dist_q;
  assign res_o.used_samples  = out_used_q;

  // trimmed sum scaled by 17, drop the extremes from the total
  assign trimmed_full = total_q - TotW'(min_q) - TotW'(max_q);
  assign trimmed      = trimmed_full[TRIM_W-1:0];
  assign scaled_d     = (SCALED_W'(trimmed) << 4) + SCALED_W'(trimmed);

  // nonzero middle samples: zeros sort to the bottom, top one is dropped
  always_comb begin
    if (zcnt_q >= ZW'(NumSamples)) begin
      n_d = '0;
    end else if (zcnt_q == '0) begin
      n_d = USED_W'(NumSamples - 2);
    end else begin
      n_d = USED_W'(ZW'(NumSamples - 1) - zcnt_q);
    end
  end

  // divide by the used count
  assign prod = ProdW'(scaled_q) * ProdW'(RECIP3);

  always_comb begin
    priority if (n_q == USED_W'(3)) begin
      dist_d = prod[RECIP_SHIFT +: DIST_W];
    end else if (n_q == USED_W'(2)) begin
      dist_d = DIST_W'(scaled_q >> 1);
    end else if (n_q == USED_W'(1)) begin
      dist_d = DIST_W'(scaled_q);
    end else begin
      dist_d = '0;
    end
  end

  assign out_load = cmd_i.out_load_tick || cmd_i.out_load_done;

  // sample store
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_en) begin
      mem_q[idx_q[AddrW-1:0]] <= store_val;
    end
    rd_q <= mem_q[sweep_idx_q];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_en) begin
      scaled_q <= scaled_d;
      n_q      <= n_d;
    end
    if (cmd_i.div_en) begin
      dist_q <= dist_d;
    end
    if (out_load) begin
      out_trig_q <= cmd_i.out_load_done ? 1'b0 : cmd_i.out_trig;
      out_busy_q <= cmd_i.out_busy;
      out_done_q <= cmd_i.out_load_done;
      out_used_q <= cmd_i.out_load_done ? n_q : '0;
    end
  end

  // control registers, counters and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_ticks_q <= TRIG_RST;
      timeout_q    <= TIMEOUT_RST;
      prescale_q   <= PRESCALE_RST;
      max_count_q  <= MAXCNT_RST;
      gap_q        <= GAP_RST;
      tick_q       <= '0;
      pre_q        <= '0;
      ec_q         <= '0;
      idx_q        <= '0;
      rd_vld_q     <= 1'b0;
      sweep_idx_q  <= '0;
      total_q      <= '0;
      min_q        <= '1;
      max_q        <= '0;
      zcnt_q       <= '0;
      out_vld_q    <= 1'b0;
      last_dist_q  <= '0;
    end else begin
      // register writes
      if (cfg_i.valid) begin
        unique case (cfg_reg_e'(cfg_i.index))
          REG_TRIGGER_TICKS:  trig_ticks_q <= cfg_i.data[TRIG_W-1:0];
          REG_ECHO_TIMEOUT:   timeout_q    <= cfg_i.data[TIMEOUT_W-1:0];
          REG_COUNT_PRESCALE: prescale_q   <= cfg_i.data[PRESCALE_W-1:0];
          REG_MAX_COUNT:      max_count_q  <= cfg_i.data[MAXCNT_W-1:0];
          REG_GAP_TICKS:      gap_q        <= cfg_i.data[GAP_W-1:0];
          default: ;
        endcase
      end

      // phase tick counter
      if (cmd_i.tick_clr) begin
        tick_q <= '0;
      end else if (cmd_i.tick_inc) begin
        tick_q <= tick_q + TICK_W'(1);
      end

      // echo width counter
      if (cmd_i.cnt_step && !stop_low) begin
        pre_q <= wrap ? '0 : pre_inc;
        ec_q  <= wrap ? ec_inc : ec_eff;
      end

      // sample index
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.store_en) begin
        idx_q <= idx_q + IdxW'(1);
      end

      // sweep address, read data follows in the next cycle
      rd_vld_q <= cmd_i.sweep_rd;
      if (cmd_i.sweep_start) begin
        sweep_idx_q <= '0;
      end else if (cmd_i.sweep_rd && !status_o.sweep_last) begin
        sweep_idx_q <= sweep_idx_q + AddrW'(1);
      end

      // sum, extremes and zero count over the stored samples
      if (cmd_i.sweep_start) begin
        total_q <= '0;
        min_q   <= '1;
        max_q   <= '0;
        zcnt_q  <= '0;
      end else if (rd_vld_q) begin
        total_q <= total_q + TotW'(rd_q);
        if (rd_q < min_q) begin
          min_q <= rd_q;
        end
        if (rd_q > max_q) begin
          max_q <= rd_q;
        end
        if (rd_q == '0) begin
          zcnt_q <= zcnt_q + ZW'(1);
        end
      end

      // output word valid and held distance
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (cmd_i.out_load_done) begin
        last_dist_q <= dist_q;
      end
    end
  end

endmodule
